>>> rtl/core/pffl_pkg.sv
// Shared types, constants and helpers of the page frame free-list allocator.
package pffl_pkg;

  localparam int unsigned PAGE_W          = 16;
  localparam int unsigned COUNT_W         = 17;
  localparam int unsigned KIND_W          = 2;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CFG_DATA_W      = 17;
  localparam int unsigned FRAME_COUNT_DEF = 65536;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD   = 2'd0,
    KIND_ALLOC = 2'd1,
    KIND_FREE  = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_OOM      = 2'd1,
    STATUS_RESERVED = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOOT_BASE  = 2'd0,
    REG_BOOT_COUNT = 2'd1
  } cfg_reg_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    push;        // link the frame in as the new head
    logic    usable_inc;  // count one more usable frame
    logic    rd_issue;    // read the link of the current head
    logic    pop_done;    // make the fetched link the new head
    logic    res_load;    // capture a result word
    status_e status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic list_empty;
    logic reserved;
    logic res_full;
  } sts_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   granted_page;
    logic [COUNT_W-1:0]  free_count;
    logic [COUNT_W-1:0]  total_usable;
  } res_t;

  // Saturating increment of a frame counter.
  function automatic logic [COUNT_W-1:0] count_inc(input logic [COUNT_W-1:0] v);
    logic [COUNT_W-1:0] r;
    r = (v == COUNT_MAX) ? v : v + COUNT_W'(1);
    return r;
  endfunction

endpackage

>>> rtl/core/pffl_chan_if.sv
// Valid/ready channel interfaces of the page frame free-list allocator.
interface pffl_item_if import pffl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [PAGE_W-1:0] page_number;

  modport source (output valid, output kind, output page_number, input ready);
  modport sink   (input valid, input kind, input page_number, output ready);
endinterface

interface pffl_result_if import pffl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [PAGE_W-1:0]   granted_page;
  logic [COUNT_W-1:0]  free_count;
  logic [COUNT_W-1:0]  total_usable;

  modport source (output valid, output status, output granted_page, output free_count,
                  output total_usable, input ready);
  modport sink   (input valid, input status, input granted_page, input free_count,
                  input total_usable, output ready);
endinterface

interface pffl_cfg_if import pffl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/pffl_ctrl.sv
// Controller state machine: decodes each word and sequences the datapath.
module pffl_ctrl import pffl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [KIND_W-1:0] in_kind_i,
  output logic              in_ready_o,
  input  sts_t              sts_i,
  output cmd_t              cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_POP  = 1'b1;

  logic state_q, state_d;
  logic accept;

  assign in_ready_o = (state_q == ST_IDLE) && !sts_i.res_full;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.status = STATUS_OK;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_kind_i)
            KIND_ADD: begin
              cmd_o.usable_inc = 1'b1;
              cmd_o.res_load   = 1'b1;
              if (sts_i.reserved) begin
                cmd_o.status = STATUS_RESERVED;
              end else begin
                cmd_o.push = 1'b1;
              end
            end
            KIND_ALLOC: begin
              if (sts_i.list_empty) begin
                cmd_o.status   = STATUS_OOM;
                cmd_o.res_load = 1'b1;
              end else begin
                cmd_o.rd_issue = 1'b1;
                state_d        = ST_POP;
              end
            end
            KIND_FREE: begin
              cmd_o.push     = 1'b1;
              cmd_o.res_load = 1'b1;
            end
            default: begin
              // Unknown kind leaves the state alone and reports the counts.
              cmd_o.res_load = 1'b1;
            end
          endcase
        end
      end
      ST_POP: begin
        cmd_o.pop_done = 1'b1;
        cmd_o.res_load = 1'b1;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_pop_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_issue |=> cmd_o.pop_done)
    else $error("link read not followed by pop");

endmodule

>>> rtl/core/pffl_dp.sv
// Datapath: link memory, list head, counters, bootstrap window and result buffer.
module pffl_dp import pffl_pkg::*; #(
  parameter int unsigned FRAME_COUNT = FRAME_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [PAGE_W-1:0] page_number_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  pffl_cfg_if.sink          cfg_i,
  pffl_result_if.source     result_o
);

  localparam int unsigned IDX_W  = $clog2(FRAME_COUNT);
  localparam int unsigned LINK_W = IDX_W + 1;
  localparam int unsigned PEXT_W = (IDX_W > PAGE_W) ? IDX_W : PAGE_W;
  localparam int unsigned HEXT_W = (LINK_W > PAGE_W) ? LINK_W : PAGE_W;

  // Link memory: one port written, one read, read data registered.
  logic [LINK_W-1:0] link_mem [FRAME_COUNT];
  logic [LINK_W-1:0] link_rd_q;

  logic [LINK_W-1:0]  head_q, head_d;
  logic [COUNT_W-1:0] free_q, free_d;
  logic [COUNT_W-1:0] usable_q, usable_d;
  logic [PAGE_W-1:0]  boot_base_q;
  logic [COUNT_W-1:0] boot_count_q;

  logic [PEXT_W-1:0] page_ext;
  logic [IDX_W-1:0]  frame;
  logic [HEXT_W-1:0] head_ext;
  logic [PAGE_W-1:0] page_off;
  logic              reserved;

  // Two-entry result buffer.
  res_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       out_pop;
  res_t       res;

  assign page_ext = PEXT_W'(page_number_i);
  assign frame    = page_ext[IDX_W-1:0];
  assign head_ext = HEXT_W'(head_q);

  assign page_off = page_number_i - boot_base_q;
  assign reserved = (page_number_i >= boot_base_q) &&
                    ({1'b0, page_off} < boot_count_q);

  assign sts_o.list_empty = head_q[IDX_W];
  assign sts_o.reserved   = reserved;
  assign sts_o.res_full   = (cnt_q == 2'd2);

  always_comb begin
    head_d   = head_q;
    free_d   = free_q;
    usable_d = usable_q;
    if (cmd_i.usable_inc) begin
      usable_d = count_inc(usable_q);
    end
    if (cmd_i.push) begin
      head_d = {1'b0, frame};
      free_d = count_inc(free_q);
    end else if (cmd_i.pop_done) begin
      head_d = link_rd_q;
      if (free_q != '0) begin
        free_d = free_q - COUNT_W'(1);
      end
    end
  end

  always_comb begin
    res.status       = cmd_i.status;
    res.granted_page = cmd_i.pop_done ? head_ext[PAGE_W-1:0] : '0;
    res.free_count   = free_d;
    res.total_usable = usable_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      link_mem[frame] <= head_q;
    end
    if (cmd_i.rd_issue) begin
      link_rd_q <= link_mem[head_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= {1'b1, {IDX_W{1'b0}}};
      free_q       <= '0;
      usable_q     <= '0;
      boot_base_q  <= '0;
      boot_count_q <= '0;
    end else begin
      head_q   <= head_d;
      free_q   <= free_d;
      usable_q <= usable_d;
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          REG_BOOT_BASE:  boot_base_q  <= cfg_i.data[PAGE_W-1:0];
          REG_BOOT_COUNT: boot_count_q <= cfg_i.data[COUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign cfg_i.ready = 1'b1;

  assign out_pop = result_o.valid && result_o.ready;

  always_comb begin
    cnt_d = cnt_q;
    unique case ({cmd_i.res_load, out_pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      slot_q[wr_ptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.res_load) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (out_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  assign result_o.valid        = (cnt_q != 2'd0);
  assign result_o.status       = slot_q[rd_ptr_q].status;
  assign result_o.granted_page = slot_q[rd_ptr_q].granted_page;
  assign result_o.free_count   = slot_q[rd_ptr_q].free_count;
  assign result_o.total_usable = slot_q[rd_ptr_q].total_usable;

  a_empty_no_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q[IDX_W] |-> (free_q == '0))
    else $error("free count nonzero with an empty list");

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.res_load && cnt_q == 2'd2) |-> out_pop)
    else $error("result written into a full buffer");

  a_no_push_on_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop_done |-> !cmd_i.push && $past(cmd_i.rd_issue))
    else $error("pop without a preceding link read");

endmodule

>>> rtl/core/page_frame_free_list_allocator.sv
// Top level of the page frame free-list allocator: controller plus datapath.
// Results: add, free, unknown and out-of-memory words load their result into the buffer
// on acceptance; a granted allocate first reads the head's link from the link memory's
// registered port and loads its result in the pop state, taking no new word meanwhile.
// Throughput: one add or free per cycle while a result slot is free; up to two results wait.
// Reset (asynchronous, active low): list empty, counts and bootstrap window zero;
// the link memory is not cleared, and words are accepted once reset is released.
module page_frame_free_list_allocator import pffl_pkg::*; #(
  // Number of frames the link memory holds; a power of two.
  parameter int unsigned FRAME_COUNT = FRAME_COUNT_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pffl_item_if.sink     item_i,
  pffl_cfg_if.sink      cfg_i,
  pffl_result_if.source result_o
);

  // The controller owns the sequencing: it decides, for each accepted word, which
  // datapath operations happen and which status the result carries. The datapath
  // reports back whether the list is empty, whether the page falls inside the
  // bootstrap window, and whether the result buffer has room.
  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  pffl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_kind_i  (item_i.kind),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // A word is taken only while no allocate is in flight and the two-entry result
  // buffer has a free slot, so a stalled sink never loses a result.
  assign item_i.ready = in_ready;

  // The datapath holds the link memory, the head pointer, both counters, the
  // bootstrap window registers and the result buffer that drives the output.
  pffl_dp #(
    .FRAME_COUNT (FRAME_COUNT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .page_number_i (item_i.page_number),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_i         (cfg_i),
    .result_o      (result_o)
  );

endmodule

>>> bench/tb_page_frame_free_list_allocator.sv
// Self-checking testbench of the page frame free-list allocator.
module tb_page_frame_free_list_allocator;
  import pffl_pkg::*;

  // Unused kind and register codes, which the block must treat as no-ops.
  localparam logic [KIND_W-1:0]    KIND_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3  = 2'd3;

  // The list is empty when its head holds the frame count itself.
  localparam logic [COUNT_W-1:0]   NO_FRAME     = COUNT_W'(FRAME_COUNT_DEF);

  // Cycles with no handshake on any channel before the run is declared hung.
  // The longest legitimate quiet spell is a sender gap or a long receiver
  // stall, so this leaves a wide margin.
  localparam int unsigned HANG_LIMIT   = 2000;
  // Cycles allowed after the last result before a register write or the end.
  localparam int unsigned SETTLE_TICKS = 4;

  typedef enum logic [1:0] {
    RX_OPEN,   // ready every cycle
    RX_COIN,   // ready on a coin toss
    RX_BURSTY  // mostly ready, with occasional long stalls
  } rx_mode_e;

  logic clk;
  logic rst_n;

  pffl_item_if   item_if ();
  pffl_cfg_if    cfg_if ();
  pffl_result_if res_if ();

  page_frame_free_list_allocator u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .item_i  (item_if),
    .cfg_i   (cfg_if),
    .result_o(res_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predicted state of the allocator. The link memory is only ever read at the
  // current head, and every frame that reaches the head was linked in by a
  // push first, so its contents before the first write never matter.
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0] link_of [FRAME_COUNT_DEF];
  logic [COUNT_W-1:0] head_frame    = NO_FRAME;
  logic [COUNT_W-1:0] frames_free   = '0;
  logic [COUNT_W-1:0] frames_usable = '0;
  logic [PAGE_W-1:0]  boot_base     = '0;
  logic [COUNT_W-1:0] boot_count    = '0;

  // Frames handed out and not yet given back, used to build sensible frees.
  logic [PAGE_W-1:0]  handed_out [$];

  res_t               pending_results [$];
  int unsigned        error_count = 0;

  // Sender pacing.
  int unsigned        burst_left    = 0;

  function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic void link_in(input logic [PAGE_W-1:0] frame);
    link_of[frame] = head_frame;
    head_frame     = {1'b0, frame};
    frames_free    = bump(frames_free);
  endfunction

  // Applies one word to the predicted state and returns the result it must give.
  function automatic res_t next_allocator_result(input logic [KIND_W-1:0] kind,
                                                 input logic [PAGE_W-1:0] page);
    res_t r;
    bit   in_boot;
    r = '0;
    case (kind)
      KIND_ADD: begin
        // The window is compared in plain integers so that it never wraps.
        in_boot = (int'(page) >= int'(boot_base)) &&
                  (int'(page) - int'(boot_base) < int'(boot_count));
        frames_usable = bump(frames_usable);
        if (in_boot) begin
          r.status = STATUS_RESERVED;
        end else begin
          link_in(page);
        end
      end
      KIND_ALLOC: begin
        if (head_frame >= NO_FRAME) begin
          r.status = STATUS_OOM;
        end else begin
          r.granted_page = head_frame[PAGE_W-1:0];
          handed_out.push_back(head_frame[PAGE_W-1:0]);
          head_frame = link_of[head_frame[PAGE_W-1:0]];
          // The free count never goes below zero, even with frames still listed.
          if (frames_free != '0) begin
            frames_free = frames_free - 1'b1;
          end
        end
      end
      KIND_FREE: begin
        link_in(page);
      end
      default: begin
        // An unknown kind leaves everything as it was.
      end
    endcase
    r.free_count   = frames_free;
    r.total_usable = frames_usable;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. Words go out in bursts of random length with random gaps in
  // between; a long burst now and then gives stretches with no idling at all.
  // valid is only lowered when a gap is really taken, so a word that follows
  // straight on keeps valid high without a second assignment in the same step.
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic [KIND_W-1:0] kind, input logic [PAGE_W-1:0] page);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        item_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 60 : 10);
    end
    burst_left--;
    item_if.valid       <= 1'b1;
    item_if.kind        <= kind;
    item_if.page_number <= page;
    do @(posedge clk); while (!item_if.ready);
    pending_results.push_back(next_allocator_result(kind, page));
  endtask

  // Stops sending and waits until every expected result has come back, then
  // gives the block time to finish any internal work.
  task automatic drain_results();
    item_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    drain_results();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_BOOT_BASE:  boot_base  = data[PAGE_W-1:0];
      REG_BOOT_COUNT: boot_count = data;
      default: begin
        // Spare indexes have no register behind them.
      end
    endcase
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_boot_window(input logic [CFG_DATA_W-1:0] base,
                                 input logic [CFG_DATA_W-1:0] count);
    write_reg(REG_BOOT_BASE, base);
    write_reg(REG_BOOT_COUNT, count);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side. The ready pattern switches at random between
  // always ready, a coin toss and rare long stalls, so that back-pressure lands
  // on every phase of an allocate.
  // ---------------------------------------------------------------------------
  rx_mode_e    rx_mode      = RX_OPEN;
  int unsigned rx_mode_left = 0;
  int unsigned rx_stall     = 0;

  always @(posedge clk) begin : rx_pattern
    logic take;
    take = 1'b1;
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_e'($urandom_range(0, 2));
      rx_mode_left = $urandom_range(100, 300);
    end
    rx_mode_left--;
    case (rx_mode)
      RX_COIN: take = 1'($urandom_range(0, 1));
      RX_BURSTY: begin
        if (rx_stall != 0) begin
          rx_stall--;
          take = 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
          rx_stall = $urandom_range(5, 20);
          take = 1'b0;
        end
      end
      default: take = 1'b1;
    endcase
    res_if.ready <= take;
  end

  task automatic compare_field(input string name, input logic [COUNT_W-1:0] want,
                               input logic [COUNT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Every accepted result word is checked against the oldest expectation.
  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word with none expected, expected nothing, actual %0h/%0h/%0h/%0h",
                 $time, res_if.status, res_if.granted_page, res_if.free_count,
                 res_if.total_usable);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("status", COUNT_W'(want.status), COUNT_W'(res_if.status));
        compare_field("granted_page", COUNT_W'(want.granted_page),
                      COUNT_W'(res_if.granted_page));
        compare_field("free_count", want.free_count, res_if.free_count);
        compare_field("total_usable", want.total_usable, res_if.total_usable);
      end
    end
  end

  // Watchdog: the run is hung if no channel moves a word for too long.
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= HANG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Allocation from an empty list, pushes of the extreme frames, an unknown
  // kind, a frame freed twice and a list popped until its free count has reached zero.
  task automatic test_list_basics();
    send_word(KIND_ALLOC, 16'h0000);
    send_word(KIND_ADD, 16'h0000);
    send_word(KIND_ADD, 16'hFFFF);
    send_word(KIND_ADD, 16'h5555);
    send_word(KIND_ADD, 16'hAAAA);
    send_word(KIND_UNUSED, 16'hFFFF);
    send_word(KIND_ALLOC, 16'hFFFF);
    send_word(KIND_ALLOC, 16'h0000);
    send_word(KIND_FREE, 16'hFFFF);
    send_word(KIND_FREE, 16'hFFFF);
    repeat (5) send_word(KIND_ALLOC, 16'h1234);
    handed_out.delete();
  endtask

  // Edges of the bootstrap window, a window reaching past the top frame that
  // must not wrap, a window covering everything, a base written with a bit
  // above its width, and writes to spare register indexes.
  task automatic test_bootstrap_window();
    set_boot_window(17'h01000, 17'h01000);
    send_word(KIND_ADD, 16'h0FFF);
    send_word(KIND_ADD, 16'h1000);
    send_word(KIND_ADD, 16'h1FFF);
    send_word(KIND_ADD, 16'h2000);
    set_boot_window(17'h0FFFF, 17'h10000);
    send_word(KIND_ADD, 16'hFFFF);
    send_word(KIND_ADD, 16'hFFFE);
    set_boot_window(17'h00000, 17'h10000);
    send_word(KIND_ADD, 16'h0000);
    send_word(KIND_ADD, 16'hFFFF);
    set_boot_window(17'h1FFFF, 17'h00000);
    send_word(KIND_ADD, 16'hFFFF);
    write_reg(REG_SPARE_2, 17'h1FFFF);
    write_reg(REG_SPARE_3, 17'h1FFFF);
    send_word(KIND_ADD, 16'h1000);
  endtask

  // Mixed traffic over several window settings. Most frees give back a frame
  // that was handed out; the rest free arbitrary frames, double frees among
  // them. Part of the adds aim at the window and just past its end.
  task automatic test_random_traffic();
    int unsigned pick;
    int unsigned slot;
    logic [PAGE_W-1:0] page;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_boot_window(17'h00000, 17'h00000);
        1: set_boot_window(17'h0FFFF, 17'h10000);
        2: set_boot_window(17'h00000, 17'h10000);
        default: set_boot_window(CFG_DATA_W'($urandom_range(0, 17'h1FFFF)),
                                 CFG_DATA_W'($urandom_range(1, 17'h04000)));
      endcase
      for (int n = 0; n < 170; n++) begin
        // Once in the run, hold off until the block has answered everything.
        if (phase == 3 && n == 90) begin
          drain_results();
        end
        pick = $urandom_range(0, 99);
        page = PAGE_W'($urandom);
        if (pick < 38) begin
          if (boot_count != '0 && $urandom_range(0, 3) == 0) begin
            page = PAGE_W'(int'(boot_base) + $urandom_range(0, int'(boot_count)));
          end
          send_word(KIND_ADD, page);
        end else if (pick < 72) begin
          send_word(KIND_ALLOC, page);
        end else if (pick < 96) begin
          if (handed_out.size() != 0 && $urandom_range(0, 9) < 8) begin
            slot = $urandom_range(0, handed_out.size() - 1);
            page = handed_out[slot];
            handed_out.delete(slot);
          end
          send_word(KIND_FREE, page);
        end else begin
          send_word(KIND_UNUSED, page);
        end
      end
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    item_if.valid       = 1'b0;
    item_if.kind        = KIND_ADD;
    item_if.page_number = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = REG_BOOT_BASE;
    cfg_if.data         = '0;
    res_if.ready        = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_list_basics();
    test_bootstrap_window();
    test_random_traffic();

    drain_results();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
